### src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### src/smfp_pkg.sv
package smfp_pkg;

  // One RBSP byte of the NAL unit
  typedef struct packed {
    logic [7:0] rbsp_byte;
    logic       end_of_nal;
  } in_item_t;

  // One message report or end of NAL summary
  typedef struct packed {
    logic        result_kind;
    logic [11:0] msg_offset;
    logic [12:0] msg_length;
    logic [15:0] payload_kind;
    logic [12:0] payload_bytes;
    logic        drop_message;
    logic        malformed;
    logic        removed_any;
    logic [12:0] kept_length;
    logic        strip_applies;
    logic        last_result;
  } result_t;

  // Result kinds
  localparam logic KIND_MESSAGE = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Parser phases
  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_TYPE    = 5'b00010,
    PH_SIZE    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DEAD    = 5'b10000
  } phase_t;

  localparam logic [7:0] RUN_BYTE = 8'hFF;
  localparam logic [15:0] RUN_STEP = 16'd255;
  localparam logic [15:0] TYPE_MAX = 16'hFFFF;
  localparam logic [15:0] SIG_TYPE = 16'd4;
  localparam int unsigned SIG_LEN = 4;
  localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{8'hB4, 8'h00, 8'h50, 8'h00};

  // Result queue: deep enough for two results per item
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned COUNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

### src/smfp_stream_if.sv
interface smfp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/sei_message_filter_parser.sv
// Results are registered into the result queue when their byte is accepted and leave it in order.
// Throughput: one RBSP byte per cycle; the parse update is one short step per byte.
// The final byte of a NAL that also closes a message gives two results, which
// leave the four-entry result queue one per cycle while report.ready is high; input stalls below two free entries.
// Reset: synchronous rst clears the parser to message start and empties the queue.
`include "assert_macros.svh"

module sei_message_filter_parser import smfp_pkg::*; #(
  parameter int unsigned MAX_RBSP_BYTES = 4096
) (
  input logic         clk,
  input logic         rst,
  smfp_stream_if.sink   rbsp,
  smfp_stream_if.source report
);

  localparam int unsigned POS_W = $clog2(MAX_RBSP_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_RBSP_BYTES);

  // Parser state
  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] message_start, message_start_next;
  logic [15:0]      type_sum, type_sum_next;
  logic [POS_W-1:0] size_sum, size_sum_next;
  logic [POS_W-1:0] payload_left, payload_left_next;
  logic [2:0]       signature_match, signature_match_next;
  logic             removed_seen, removed_seen_next;
  logic             malformed_seen, malformed_seen_next;
  logic [POS_W-1:0] kept_total, kept_total_next;

  // Result queue
  result_t            fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   head, head_next;
  logic [PTR_W-1:0]   tail, tail_next;
  logic [COUNT_W-1:0] count, count_next;

  logic       accept, pop, eon;
  logic [7:0] b;
  phase_t     cur_phase;
  logic       finish;
  logic [16:0] type_add;
  logic [POS_W:0] size_add_wide;
  logic [POS_W-1:0] size_add;
  logic [POS_W-1:0] pay_idx;
  logic       sig_hit;
  logic [POS_W-1:0] msg_len;
  logic [POS_W:0] kept_add_wide;
  logic       drop;
  result_t    msg_res, sum_res, first_res;
  logic [1:0] n_push;

  assign b      = rbsp.payload.rbsp_byte;
  assign eon    = rbsp.payload.end_of_nal;
  assign accept = rbsp.valid && rbsp.ready;
  assign pop    = report.valid && report.ready;

  // Saturating adders and signature check
  assign type_add      = {1'b0, type_sum} + 17'(b);
  assign size_add_wide = (POS_W+1)'(size_sum) + (POS_W+1)'(b);
  assign size_add      = (size_add_wide > (POS_W+1)'(POS_MAX)) ? POS_MAX
                                                               : size_add_wide[POS_W-1:0];
  assign pay_idx = size_sum - payload_left;
  assign sig_hit = (type_sum == SIG_TYPE) && (size_sum >= POS_W'(SIG_LEN))
                   && (pay_idx < POS_W'(SIG_LEN))
                   && (signature_match == {1'b0, pay_idx[1:0]})
                   && (b == SIG_BYTES[pay_idx[1:0]]);
  assign msg_len = byte_position + POS_W'(1) - message_start;

  // Per-byte parse step
  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    message_start_next   = message_start;
    type_sum_next        = type_sum;
    size_sum_next        = size_sum;
    payload_left_next    = payload_left;
    signature_match_next = signature_match;
    removed_seen_next    = removed_seen;
    malformed_seen_next  = malformed_seen;
    kept_total_next      = kept_total;
    finish               = 1'b0;
    drop                 = 1'b0;
    kept_add_wide        = '0;
    msg_res              = '0;
    sum_res              = '0;
    cur_phase            = phase;

    // overlong NAL: stop parsing
    if (phase != PH_DEAD && byte_position >= POS_MAX) begin
      malformed_seen_next = 1'b1;
      cur_phase           = PH_DEAD;
      phase_next          = PH_DEAD;
    end
    if (cur_phase != PH_DEAD) begin
      byte_position_next = byte_position + POS_W'(1);
    end

    unique case (cur_phase)
      PH_START: begin
        // a start byte that ends the NAL is trailing bits
        if (!eon) begin
          message_start_next   = byte_position;
          size_sum_next        = '0;
          signature_match_next = '0;
          if (b == RUN_BYTE) begin
            type_sum_next = RUN_STEP;
            phase_next    = PH_TYPE;
          end else begin
            type_sum_next = 16'(b);
            phase_next    = PH_SIZE;
          end
        end
      end
      PH_TYPE: begin
        type_sum_next = type_add[16] ? TYPE_MAX : type_add[15:0];
        if (b != RUN_BYTE) phase_next = PH_SIZE;
        if (eon) malformed_seen_next = 1'b1;
      end
      PH_SIZE: begin
        size_sum_next = size_add;
        if (b != RUN_BYTE) begin
          if (size_add == '0) begin
            finish = 1'b1;
          end else begin
            payload_left_next = size_add;
            phase_next        = PH_PAYLOAD;
            if (eon) malformed_seen_next = 1'b1;
          end
        end else if (eon) begin
          malformed_seen_next = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (sig_hit) signature_match_next = signature_match + 3'd1;
        payload_left_next = payload_left - POS_W'(1);
        if (payload_left == POS_W'(1)) begin
          finish = 1'b1;
        end else if (eon) begin
          malformed_seen_next = 1'b1;
        end
      end
      PH_DEAD: begin
      end
      default: begin
      end
    endcase

    // message complete: report and clear message state
    if (finish) begin
      drop                  = (signature_match_next == 3'(SIG_LEN));
      msg_res.result_kind   = KIND_MESSAGE;
      msg_res.msg_offset    = 12'(message_start);
      msg_res.msg_length    = 13'(msg_len);
      msg_res.payload_kind  = type_sum_next;
      msg_res.payload_bytes = 13'(size_sum_next);
      msg_res.drop_message  = drop;
      msg_res.last_result   = !eon;
      if (drop) begin
        removed_seen_next = 1'b1;
      end else begin
        kept_add_wide   = (POS_W+1)'(kept_total) + (POS_W+1)'(msg_len);
        kept_total_next = (kept_add_wide > (POS_W+1)'(POS_MAX)) ? POS_MAX
                                                                : kept_add_wide[POS_W-1:0];
      end
      phase_next           = PH_START;
      type_sum_next        = '0;
      size_sum_next        = '0;
      payload_left_next    = '0;
      signature_match_next = '0;
    end

    // end of NAL: summary, then back to reset state
    if (eon) begin
      sum_res.result_kind   = KIND_SUMMARY;
      sum_res.malformed     = malformed_seen_next;
      sum_res.removed_any   = removed_seen_next;
      sum_res.kept_length   = 13'(kept_total_next);
      sum_res.strip_applies = removed_seen_next && !malformed_seen_next;
      sum_res.last_result   = 1'b1;
      phase_next           = PH_START;
      byte_position_next   = '0;
      message_start_next   = '0;
      type_sum_next        = '0;
      size_sum_next        = '0;
      payload_left_next    = '0;
      signature_match_next = '0;
      removed_seen_next    = 1'b0;
      malformed_seen_next  = 1'b0;
      kept_total_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      byte_position   <= '0;
      message_start   <= '0;
      type_sum        <= '0;
      size_sum        <= '0;
      payload_left    <= '0;
      signature_match <= '0;
      removed_seen    <= 1'b0;
      malformed_seen  <= 1'b0;
      kept_total      <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      message_start   <= message_start_next;
      type_sum        <= type_sum_next;
      size_sum        <= size_sum_next;
      payload_left    <= payload_left_next;
      signature_match <= signature_match_next;
      removed_seen    <= removed_seen_next;
      malformed_seen  <= malformed_seen_next;
      kept_total      <= kept_total_next;
    end
  end

  // Result queue push and pop
  assign n_push    = accept ? (2'(finish) + 2'(eon)) : 2'd0;
  assign first_res = finish ? msg_res : sum_res;
  assign head_next  = pop ? head + PTR_W'(1) : head;
  assign tail_next  = tail + PTR_W'(n_push);
  assign count_next = count + COUNT_W'(n_push) - COUNT_W'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) fifo_q[tail] <= first_res;
    if (n_push == 2'd2) fifo_q[tail + PTR_W'(1)] <= sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  assign rbsp.ready     = (count <= COUNT_W'(FIFO_DEPTH - 2));
  assign report.valid   = (count != '0);
  assign report.payload = fifo_q[head];

  `ASSERT_CLK(a_fifo_bound, count <= COUNT_W'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_CLK(a_dead_malformed, (phase == PH_DEAD) |-> malformed_seen, "dead phase without malformed")
  `ASSERT_CLK(a_nal_end_clear, (accept && eon) |=> (phase == PH_START && byte_position == '0 && count != '0), "end of NAL did not clear or emit summary")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !report.valid, "result offered right after reset")

endmodule
